// ===== hw/rtl/rsgc_pkg.sv =====
// Package for the RS steganalysis group counter.
// Field widths, group phase codes and the classifier result type.
// No dependencies.
`default_nettype none

package rsgc_pkg;

  localparam int unsigned COEF_WIDTH  = 16;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned OUT_WIDTH   = 32;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_MIDDLE = 2'd1;
  localparam logic [1:0] PHASE_LAST   = 2'd2;

  typedef struct packed {
    logic reg_plus;
    logic sng_plus;
    logic reg_minus;
    logic sng_minus;
  } class_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rsgc_classify.sv =====
// Classifies one triple (a, b, c) as regular or singular under both masks.
// Depends on rsgc_pkg.
`default_nettype none

module rsgc_classify #(
  parameter int unsigned CoefWidth = rsgc_pkg::COEF_WIDTH
) (
  input  wire logic signed [CoefWidth-1:0] a_i,
  input  wire logic signed [CoefWidth-1:0] b_i,
  input  wire logic signed [CoefWidth-1:0] c_i,
  output rsgc_pkg::class_t                 class_o
);

  localparam int unsigned NW = CoefWidth + 3;

  logic signed [NW-1:0] a_x, b_x, c_x, b_inc, b_dec, fb_plus, fb_minus;
  logic        [NW-1:0] n_base, n_plus, n_minus;

  function automatic logic [NW-1:0] noise3(input logic signed [NW-1:0] a,
                                           input logic signed [NW-1:0] b,
                                           input logic signed [NW-1:0] c);
    logic signed [NW-1:0] d0, d1;
    logic        [NW-1:0] s;
    d0 = b - a;
    d1 = c - b;
    if (d0 < 0) d0 = -d0;
    if (d1 < 0) d1 = -d1;
    s = NW'(d0) + NW'(d1);
    return s >> 1;
  endfunction

  always_comb begin
    a_x      = NW'(a_i);
    b_x      = NW'(b_i);
    c_x      = NW'(c_i);
    b_inc    = b_x + NW'(1);
    b_dec    = b_x - NW'(1);
    // even: plus goes up, minus goes down; odd: the reverse
    fb_plus  = b_i[0] ? b_dec : b_inc;
    fb_minus = b_i[0] ? b_inc : b_dec;
    n_base   = noise3(a_x, b_x, c_x);
    n_plus   = noise3(a_x, fb_plus, c_x);
    n_minus  = noise3(a_x, fb_minus, c_x);
    class_o.reg_plus  = n_plus > n_base;
    class_o.sng_plus  = n_plus < n_base;
    class_o.reg_minus = n_minus > n_base;
    class_o.sng_minus = n_minus < n_base;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rs_steganalysis_group_counter.sv =====
// RS steganalysis group counter: registered input stage and registered valid_o.
// Throughput one item per cycle; an item marked last stalls the input only while
// the previous result still waits in the output register.
// rst_ni (async, active low) clears phase, counters and valid flags.
// Depends on rsgc_pkg and rsgc_classify.
`default_nettype none

module rs_steganalysis_group_counter #(
  parameter int unsigned CoefWidth  = rsgc_pkg::COEF_WIDTH,
  parameter int unsigned CountWidth = rsgc_pkg::COUNT_WIDTH
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  output logic                                  stall_o,
  input  wire logic signed [CoefWidth-1:0]      coefficient_i,
  input  wire logic                             last_coefficient_i,
  output logic                                  valid_o,
  input  wire logic                             stall_i,
  output logic [rsgc_pkg::OUT_WIDTH-1:0]        regular_plus_o,
  output logic [rsgc_pkg::OUT_WIDTH-1:0]        singular_plus_o,
  output logic [rsgc_pkg::OUT_WIDTH-1:0]        regular_minus_o,
  output logic [rsgc_pkg::OUT_WIDTH-1:0]        singular_minus_o,
  output logic [rsgc_pkg::OUT_WIDTH-1:0]        coefficient_total_o
);

  localparam int unsigned OW = rsgc_pkg::OUT_WIDTH;
  localparam int unsigned EW = (CountWidth > OW) ? CountWidth : OW;

  // input stage
  logic                        in_valid_q;
  logic signed [CoefWidth-1:0] in_coef_q;
  logic                        in_last_q;
  logic                        blocked, fire;

  // group state
  logic [1:0]                  phase_q, phase_d;
  logic signed [CoefWidth-1:0] first_q, first_d, middle_q, middle_d;
  logic [CountWidth-1:0]       rp_q, rp_d, sp_q, sp_d, rm_q, rm_d, sm_q, sm_d;
  logic [CountWidth-1:0]       seen_q, seen_d;
  logic [CountWidth-1:0]       rp_n, sp_n, rm_n, sm_n, seen_n;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [OW-1:0]               rp_out_q, sp_out_q, rm_out_q, sm_out_q, tot_out_q;

  rsgc_pkg::class_t            cls;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v,
                                                    input logic                  en);
    return (en && (v != '1)) ? v + CountWidth'(1) : v;
  endfunction

  function automatic logic [OW-1:0] to_out(input logic [CountWidth-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    return x[OW-1:0];
  endfunction

  rsgc_classify #(
    .CoefWidth(CoefWidth)
  ) u_classify (
    .a_i     (first_q),
    .b_i     (middle_q),
    .c_i     (in_coef_q),
    .class_o (cls)
  );

  assign blocked = in_last_q && out_valid_q && stall_i;
  assign stall_o = in_valid_q && blocked;
  assign fire    = in_valid_q && !blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!stall_o) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      in_coef_q <= coefficient_i;
      in_last_q <= last_coefficient_i;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    first_d  = first_q;
    middle_d = middle_q;
    rp_n     = rp_q;
    sp_n     = sp_q;
    rm_n     = rm_q;
    sm_n     = sm_q;
    case (phase_q)
      rsgc_pkg::PHASE_MIDDLE: begin
        middle_d = in_coef_q;
        phase_d  = rsgc_pkg::PHASE_LAST;
      end
      rsgc_pkg::PHASE_LAST: begin
        rp_n    = sat_inc(rp_q, cls.reg_plus);
        sp_n    = sat_inc(sp_q, cls.sng_plus);
        rm_n    = sat_inc(rm_q, cls.reg_minus);
        sm_n    = sat_inc(sm_q, cls.sng_minus);
        phase_d = rsgc_pkg::PHASE_FIRST;
      end
      default: begin
        first_d = in_coef_q;
        phase_d = rsgc_pkg::PHASE_MIDDLE;
      end
    endcase
    seen_n = sat_inc(seen_q, 1'b1);
    rp_d   = rp_n;
    sp_d   = sp_n;
    rm_d   = rm_n;
    sm_d   = sm_n;
    seen_d = seen_n;
    if (in_last_q) begin
      phase_d  = rsgc_pkg::PHASE_FIRST;
      first_d  = '0;
      middle_d = '0;
      rp_d     = '0;
      sp_d     = '0;
      rm_d     = '0;
      sm_d     = '0;
      seen_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rsgc_pkg::PHASE_FIRST;
      first_q  <= '0;
      middle_q <= '0;
      rp_q     <= '0;
      sp_q     <= '0;
      rm_q     <= '0;
      sm_q     <= '0;
      seen_q   <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      first_q  <= first_d;
      middle_q <= middle_d;
      rp_q     <= rp_d;
      sp_q     <= sp_d;
      rm_q     <= rm_d;
      sm_q     <= sm_d;
      seen_q   <= seen_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && stall_i;
    if (fire && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) begin
      rp_out_q  <= to_out(rp_n);
      sp_out_q  <= to_out(sp_n);
      rm_out_q  <= to_out(rm_n);
      sm_out_q  <= to_out(sm_n);
      tot_out_q <= to_out(seen_n);
    end
  end

  assign valid_o             = out_valid_q;
  assign regular_plus_o      = rp_out_q;
  assign singular_plus_o     = sp_out_q;
  assign regular_minus_o     = rm_out_q;
  assign singular_minus_o    = sm_out_q;
  assign coefficient_total_o = tot_out_q;

endmodule

`default_nettype wire

// ===== verif/tb_rs_steganalysis_group_counter.sv =====
// Testbench for rs_steganalysis_group_counter: directed table, then random images of
// coefficients; each result checked against typed table counts, else a local model.
// Depends on rsgc_pkg and the RTL of the counter.
`timescale 1ns / 1ps

module tb_rs_steganalysis_group_counter;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int RandomItems   = 1000;
  localparam int IdlePercent   = 38;

  typedef struct packed {
    logic [rsgc_pkg::OUT_WIDTH-1:0] regular_plus;
    logic [rsgc_pkg::OUT_WIDTH-1:0] singular_plus;
    logic [rsgc_pkg::OUT_WIDTH-1:0] regular_minus;
    logic [rsgc_pkg::OUT_WIDTH-1:0] singular_minus;
    logic [rsgc_pkg::OUT_WIDTH-1:0] coefficient_total;
  } group_counts_t;

  typedef struct {
    logic signed [rsgc_pkg::COEF_WIDTH-1:0] coef;
    logic                                   last;
    bit                                     typed;
    group_counts_t                          counts;
  } stim_row_t;

  logic                                   clk_i              = 1'b0;
  logic                                   rst_ni             = 1'b0;
  logic                                   valid_i            = 1'b0;
  logic signed [rsgc_pkg::COEF_WIDTH-1:0] coefficient_i      = '0;
  logic                                   last_coefficient_i = 1'b0;
  logic                                   stall_i            = 1'b0;
  logic                                   stall_o;
  logic                                   valid_o;
  logic [rsgc_pkg::OUT_WIDTH-1:0]         regular_plus_o;
  logic [rsgc_pkg::OUT_WIDTH-1:0]         singular_plus_o;
  logic [rsgc_pkg::OUT_WIDTH-1:0]         regular_minus_o;
  logic [rsgc_pkg::OUT_WIDTH-1:0]         singular_minus_o;
  logic [rsgc_pkg::OUT_WIDTH-1:0]         coefficient_total_o;

  group_counts_t expected_counts[$];
  int            error_count = 0;
  int            quiet_cycles = 0;
  bit            steady = 1'b0;

  // model state of the open triple and the running counts
  logic [1:0]                       phase_q = rsgc_pkg::PHASE_FIRST;
  longint                           first_q = 0;
  longint                           middle_q = 0;
  logic [rsgc_pkg::COUNT_WIDTH-1:0] reg_plus_q = '0;
  logic [rsgc_pkg::COUNT_WIDTH-1:0] sng_plus_q = '0;
  logic [rsgc_pkg::COUNT_WIDTH-1:0] reg_minus_q = '0;
  logic [rsgc_pkg::COUNT_WIDTH-1:0] sng_minus_q = '0;
  logic [rsgc_pkg::COUNT_WIDTH-1:0] seen_q = '0;

  stim_row_t dir_rows [22] = '{
    '{16'sd0, 1'b1, 1'b1, '{0, 0, 0, 0, 1}},
    '{16'sd5, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd7, 1'b1, 1'b1, '{0, 0, 0, 0, 2}},
    '{16'sh8000, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sh7FFF, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sh8000, 1'b1, 1'b1, '{0, 1, 1, 0, 3}},
    '{16'sh7FFF, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sh8000, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sh7FFF, 1'b1, 1'b1, '{0, 1, 1, 0, 3}},
    '{16'sd0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{-16'sd3, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd0, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{-16'sd4, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd0, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd1, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd2, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd3, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{16'sd0, 1'b1, 1'b0, '{0, 0, 0, 0, 0}},
    '{-16'sd1, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{-16'sd1, 1'b0, 1'b0, '{0, 0, 0, 0, 0}},
    '{-16'sd1, 1'b1, 1'b0, '{0, 0, 0, 0, 0}}
  };

  rs_steganalysis_group_counter i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .coefficient_i      (coefficient_i),
    .last_coefficient_i (last_coefficient_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .regular_plus_o     (regular_plus_o),
    .singular_plus_o    (singular_plus_o),
    .regular_minus_o    (regular_minus_o),
    .singular_minus_o   (singular_minus_o),
    .coefficient_total_o(coefficient_total_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [rsgc_pkg::COUNT_WIDTH-1:0] sat_inc(
      input logic [rsgc_pkg::COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + rsgc_pkg::COUNT_WIDTH'(1);
  endfunction

  function automatic longint triple_noise(input longint a, input longint b, input longint c);
    longint d0;
    longint d1;
    d0 = b - a;
    d1 = c - b;
    if (d0 < 0) d0 = -d0;
    if (d1 < 0) d1 = -d1;
    return (d0 + d1) / 2;
  endfunction

  // {rose, fell} of the noise when the middle value is flipped in direction dir
  function automatic logic [1:0] noise_shift(input longint a, input longint b,
                                             input longint c, input longint dir);
    longint base;
    longint flipped;
    base    = triple_noise(a, b, c);
    flipped = triple_noise(a, (b[0] == 1'b0) ? b + dir : b - dir, c);
    return {flipped > base, flipped < base};
  endfunction

  task automatic predict_group(input logic signed [rsgc_pkg::COEF_WIDTH-1:0] coef,
                               input logic last,
                               output bit emits, output group_counts_t counts);
    longint     v;
    logic [1:0] plus_shift;
    logic [1:0] minus_shift;
    v      = longint'(coef);
    emits  = 1'b0;
    counts = '0;
    case (phase_q)
      rsgc_pkg::PHASE_MIDDLE: begin
        middle_q = v;
        phase_q  = rsgc_pkg::PHASE_LAST;
      end
      rsgc_pkg::PHASE_LAST: begin
        plus_shift  = noise_shift(first_q, middle_q, v, 1);
        minus_shift = noise_shift(first_q, middle_q, v, -1);
        if (plus_shift[1]) reg_plus_q = sat_inc(reg_plus_q);
        if (plus_shift[0]) sng_plus_q = sat_inc(sng_plus_q);
        if (minus_shift[1]) reg_minus_q = sat_inc(reg_minus_q);
        if (minus_shift[0]) sng_minus_q = sat_inc(sng_minus_q);
        phase_q = rsgc_pkg::PHASE_FIRST;
      end
      default: begin
        first_q = v;
        phase_q = rsgc_pkg::PHASE_MIDDLE;
      end
    endcase
    seen_q = sat_inc(seen_q);
    if (last) begin
      emits  = 1'b1;
      counts = '{reg_plus_q[rsgc_pkg::OUT_WIDTH-1:0], sng_plus_q[rsgc_pkg::OUT_WIDTH-1:0],
                 reg_minus_q[rsgc_pkg::OUT_WIDTH-1:0], sng_minus_q[rsgc_pkg::OUT_WIDTH-1:0],
                 seen_q[rsgc_pkg::OUT_WIDTH-1:0]};
      phase_q     = rsgc_pkg::PHASE_FIRST;
      first_q     = 0;
      middle_q    = 0;
      reg_plus_q  = '0;
      sng_plus_q  = '0;
      reg_minus_q = '0;
      sng_minus_q = '0;
      seen_q      = '0;
    end
  endtask

  // mostly small values as from a quantizer, some full range and extremes
  function automatic logic signed [rsgc_pkg::COEF_WIDTH-1:0] rand_coef();
    int v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(3))
          0: v = -32768;
          1: v = -32767;
          2: v = 32766;
          default: v = 32767;
        endcase
      end
      default: v = int'($urandom_range(16)) - 8;
    endcase
    return v[rsgc_pkg::COEF_WIDTH-1:0];
  endfunction

  task automatic drive_item(input logic signed [rsgc_pkg::COEF_WIDTH-1:0] coef,
                            input logic last,
                            input bit typed, input group_counts_t typed_counts);
    bit            emits;
    group_counts_t predicted;
    while (!steady && $urandom_range(99) < IdlePercent) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i            <= 1'b1;
    coefficient_i      <= coef;
    last_coefficient_i <= last;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    predict_group(coef, last, emits, predicted);
    if (emits)
      expected_counts.insert(expected_counts.size(), typed ? typed_counts : predicted);
    @(negedge clk_i);
  endtask

  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  always @(negedge clk_i) begin
    stall_i <= !steady && ($urandom_range(99) < IdlePercent);
  end

  always @(posedge clk_i) begin : check_result
    group_counts_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_counts.size() == 0) begin
        report_error("result with nothing pending");
      end else begin
        want = expected_counts.pop_front();
        if (regular_plus_o !== want.regular_plus)
          report_error($sformatf("regular_plus got %0d want %0d",
                                 regular_plus_o, want.regular_plus));
        if (singular_plus_o !== want.singular_plus)
          report_error($sformatf("singular_plus got %0d want %0d",
                                 singular_plus_o, want.singular_plus));
        if (regular_minus_o !== want.regular_minus)
          report_error($sformatf("regular_minus got %0d want %0d",
                                 regular_minus_o, want.regular_minus));
        if (singular_minus_o !== want.singular_minus)
          report_error($sformatf("singular_minus got %0d want %0d",
                                 singular_minus_o, want.singular_minus));
        if (coefficient_total_o !== want.coefficient_total)
          report_error($sformatf("coefficient_total got %0d want %0d",
                                 coefficient_total_o, want.coefficient_total));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int item_no;
    int img_len;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i])
      drive_item(dir_rows[i].coef, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].counts);
    item_no = 0;
    while (item_no < RandomItems) begin
      img_len = ($urandom_range(19) == 0) ? $urandom_range(120, 1) : $urandom_range(12, 1);
      for (int k = 0; k < img_len; k++) begin
        steady = (item_no >= 400) && (item_no < 600);
        drive_item(rand_coef(), k == img_len - 1, 1'b0, '0);
        item_no++;
      end
    end
    steady = 1'b0;
    valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== rs_steganalysis_group_counter.f =====
hw/rtl/rsgc_pkg.sv
hw/rtl/rsgc_classify.sv
hw/rtl/rs_steganalysis_group_counter.sv
verif/tb_rs_steganalysis_group_counter.sv
